### hw/rtl/fpwo_pkg.sv
package fpwo_pkg;

	// Coordinate and distance widths, point and pair counts, and the wand point count
	localparam int CoordBits = 16;
	localparam int DistBits  = 2 * CoordBits + 1;
	localparam int NumPoints = 4;
	localparam int NumPairs  = 6;
	localparam int CountBits = 4;
	localparam logic [CountBits-1:0] WandCount = CountBits'(4);

	// Word layouts on the stream ports
	localparam int InFieldBits  = CountBits + 2 * NumPoints * CoordBits;
	localparam int InDataBits   = ((InFieldBits + 7) / 8) * 8;
	localparam int OutFieldBits = 1 + 2 * NumPoints * CoordBits;
	localparam int OutDataBits  = ((OutFieldBits + 7) / 8) * 8;

	typedef logic signed [CoordBits-1:0] coord_t;
	typedef logic [CoordBits-1:0]        mag_t;
	typedef logic [DistBits-1:0]         dist_t;
	typedef logic [DistBits:0]           ext_dist_t;
	typedef logic [1:0]                  idx_t;

	typedef struct packed {
		coord_t y;
		coord_t x;
	} point_t;

	// Point pairs, in tie-break order
	typedef enum logic [2:0] {
		PAIR_01 = 3'd0,
		PAIR_02 = 3'd1,
		PAIR_03 = 3'd2,
		PAIR_12 = 3'd3,
		PAIR_13 = 3'd4,
		PAIR_23 = 3'd5
	} pair_t;

	typedef struct packed {
		pair_t pmin;
		pair_t pmax;
	} pick_t;

	function automatic idx_t pair_lo(pair_t p);
		case (p)
			PAIR_01, PAIR_02, PAIR_03: pair_lo = 2'd0;
			PAIR_12, PAIR_13:          pair_lo = 2'd1;
			default:                   pair_lo = 2'd2;
		endcase
	endfunction

	function automatic idx_t pair_hi(pair_t p);
		case (p)
			PAIR_01:          pair_hi = 2'd1;
			PAIR_02, PAIR_12: pair_hi = 2'd2;
			default:          pair_hi = 2'd3;
		endcase
	endfunction

	function automatic pair_t pair_of(idx_t i, idx_t j);
		idx_t lo;
		idx_t hi;
		lo = (i < j) ? i : j;
		hi = (i < j) ? j : i;
		case ({lo, hi})
			4'b0001: pair_of = PAIR_01;
			4'b0010: pair_of = PAIR_02;
			4'b0011: pair_of = PAIR_03;
			4'b0110: pair_of = PAIR_12;
			4'b0111: pair_of = PAIR_13;
			default: pair_of = PAIR_23;
		endcase
	endfunction

	// Distance between two points; a point to itself reads as larger than any
	function automatic ext_dist_t dist_of(dist_t [NumPairs-1:0] d, idx_t i, idx_t j);
		ext_dist_t r;
		if (i == j) begin
			r = '1;
		end else begin
			r = {1'b0, d[pair_of(i, j)]};
		end
		return r;
	endfunction

endpackage

### hw/rtl/fpwo_dist.sv
module fpwo_dist (
	input  fpwo_pkg::point_t [fpwo_pkg::NumPoints-1:0] pts,
	output fpwo_pkg::dist_t  [fpwo_pkg::NumPairs-1:0]  sq_dist
);

	// Absolute difference of two coordinates
	function automatic fpwo_pkg::mag_t abs_diff(fpwo_pkg::coord_t a, fpwo_pkg::coord_t b);
		logic signed [fpwo_pkg::CoordBits:0] diff;
		diff = {a[fpwo_pkg::CoordBits-1], a} - {b[fpwo_pkg::CoordBits-1], b};
		if (diff[fpwo_pkg::CoordBits]) begin
			diff = -diff;
		end
		return diff[fpwo_pkg::CoordBits-1:0];
	endfunction

	// Square both axis differences and sum them for each pair
	always_comb begin
		fpwo_pkg::pair_t p;
		fpwo_pkg::mag_t  dx;
		fpwo_pkg::mag_t  dy;
		logic [2*fpwo_pkg::CoordBits-1:0] sqx;
		logic [2*fpwo_pkg::CoordBits-1:0] sqy;
		for (int k = 0; k < fpwo_pkg::NumPairs; k++) begin
			p   = fpwo_pkg::pair_t'(3'(k));
			dx  = abs_diff(pts[fpwo_pkg::pair_lo(p)].x, pts[fpwo_pkg::pair_hi(p)].x);
			dy  = abs_diff(pts[fpwo_pkg::pair_lo(p)].y, pts[fpwo_pkg::pair_hi(p)].y);
			sqx = dx * dx;
			sqy = dy * dy;
			sq_dist[k] = fpwo_pkg::DistBits'(sqx) + fpwo_pkg::DistBits'(sqy);
		end
	end

endmodule

### hw/rtl/fpwo_pick.sv
module fpwo_pick (
	input  fpwo_pkg::dist_t [fpwo_pkg::NumPairs-1:0] sq_dist,
	output fpwo_pkg::pick_t                          pick
);

	fpwo_pkg::pair_t mn_a, mn_b, mn_c, mn_ab;
	fpwo_pkg::pair_t mx_a, mx_b, mx_c, mx_ab;

	// First round: neighbors; an earlier pair wins ties
	always_comb begin
		mn_a = (sq_dist[1] < sq_dist[0]) ? fpwo_pkg::PAIR_02 : fpwo_pkg::PAIR_01;
		mn_b = (sq_dist[3] < sq_dist[2]) ? fpwo_pkg::PAIR_12 : fpwo_pkg::PAIR_03;
		mn_c = (sq_dist[5] < sq_dist[4]) ? fpwo_pkg::PAIR_23 : fpwo_pkg::PAIR_13;
		mx_a = (sq_dist[0] < sq_dist[1]) ? fpwo_pkg::PAIR_02 : fpwo_pkg::PAIR_01;
		mx_b = (sq_dist[2] < sq_dist[3]) ? fpwo_pkg::PAIR_12 : fpwo_pkg::PAIR_03;
		mx_c = (sq_dist[4] < sq_dist[5]) ? fpwo_pkg::PAIR_23 : fpwo_pkg::PAIR_13;
	end

	// Second and final rounds keep the earlier side on the left
	always_comb begin
		mn_ab = (sq_dist[mn_b] < sq_dist[mn_a]) ? mn_b : mn_a;
		mx_ab = (sq_dist[mx_a] < sq_dist[mx_b]) ? mx_b : mx_a;
		pick.pmin = (sq_dist[mn_c] < sq_dist[mn_ab]) ? mn_c : mn_ab;
		pick.pmax = (sq_dist[mx_ab] < sq_dist[mx_c]) ? mx_c : mx_ab;
	end

endmodule

### hw/rtl/fpwo_order.sv
module fpwo_order (
	input  logic                                        found,
	input  fpwo_pkg::point_t [fpwo_pkg::NumPoints-1:0] pts,
	input  fpwo_pkg::dist_t  [fpwo_pkg::NumPairs-1:0]  sq_dist,
	input  fpwo_pkg::pick_t                             pick,
	output fpwo_pkg::point_t [fpwo_pkg::NumPoints-1:0] ordered
);

	fpwo_pkg::idx_t left0, right0, mid0, cross0;
	fpwo_pkg::idx_t left1, right1, mid1, cross1;

	// Take ends from the farthest pair and middle/cross from the closest
	always_comb begin
		left0  = fpwo_pkg::pair_hi(pick.pmax);
		right0 = fpwo_pkg::pair_lo(pick.pmax);
		mid0   = fpwo_pkg::pair_hi(pick.pmin);
		cross0 = fpwo_pkg::pair_lo(pick.pmin);
	end

	// Swap middle and cross if cross sits nearer the left end
	always_comb begin
		if (fpwo_pkg::dist_of(sq_dist, cross0, left0) <
				fpwo_pkg::dist_of(sq_dist, mid0, left0)) begin
			mid1   = cross0;
			cross1 = mid0;
		end else begin
			mid1   = mid0;
			cross1 = cross0;
		end
	end

	// Swap the ends if the middle sits nearer the left end
	always_comb begin
		if (fpwo_pkg::dist_of(sq_dist, mid1, left0) <
				fpwo_pkg::dist_of(sq_dist, mid1, right0)) begin
			left1  = right0;
			right1 = left0;
		end else begin
			left1  = left0;
			right1 = right0;
		end
	end

	// Drive the points out, zeros when the count is wrong
	always_comb begin
		if (found) begin
			ordered[0] = pts[left1];
			ordered[1] = pts[mid1];
			ordered[2] = pts[right1];
			ordered[3] = pts[cross1];
		end else begin
			ordered = '0;
		end
	end

endmodule

### hw/rtl/four_point_wand_order_top.sv
// Four-point wand ordering, four-stage pipeline.
// An accepted input word passes through stages s1, s2, s3 and the output register to m_tvalid.
// Throughput: one word per cycle; the whole pipe holds only while an output word waits.
// The per-pair squarer in the distance stage sets the clock path.
// Reset (arst_n low, asynchronous) empties every stage; no output word is valid after it.
module four_point_wand_order_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// point_count[3:0], point0_x, point0_y, point1_x, point1_y,
	// point2_x, point2_y, point3_x, point3_y (16 bits each), zero pad
	input  logic [fpwo_pkg::InDataBits-1:0]    s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// found[0], left_x, left_y, mid_x, mid_y, right_x, right_y,
	// off_axis_x, off_axis_y (16 bits each), zero pad
	output logic [fpwo_pkg::OutDataBits-1:0]   m_tdata
);

	logic advance;
	logic valid_s1, valid_s2, valid_s3, valid_q;
	logic found_s1, found_s2, found_s3;
	fpwo_pkg::point_t [fpwo_pkg::NumPoints-1:0] pts_in, pts_s1, pts_s2, pts_s3, ordered;
	fpwo_pkg::dist_t [fpwo_pkg::NumPairs-1:0] dist_c, dist_s2, dist_s3;
	fpwo_pkg::pick_t pick_c, pick_s3;
	logic [fpwo_pkg::OutDataBits-1:0] data_c, data_q;

	// Move the whole pipe when the output register is free or being drained
	assign advance  = !valid_q || m_tready;
	assign s_tready = advance;
	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;

	// Unpack the input word
	always_comb begin
		for (int k = 0; k < fpwo_pkg::NumPoints; k++) begin
			pts_in[k].x = s_tdata[fpwo_pkg::CountBits + 2 * fpwo_pkg::CoordBits * k
				+: fpwo_pkg::CoordBits];
			pts_in[k].y = s_tdata[fpwo_pkg::CountBits + 2 * fpwo_pkg::CoordBits * k
				+ fpwo_pkg::CoordBits +: fpwo_pkg::CoordBits];
		end
	end

	fpwo_dist u_dist (
		.pts     (pts_s1),
		.sq_dist (dist_c)
	);

	fpwo_pick u_pick (
		.sq_dist (dist_s2),
		.pick    (pick_c)
	);

	fpwo_order u_order (
		.found   (found_s3),
		.pts     (pts_s3),
		.sq_dist (dist_s3),
		.pick    (pick_s3),
		.ordered (ordered)
	);

	// Pack the output word
	always_comb begin
		data_c    = '0;
		data_c[0] = found_s3;
		for (int k = 0; k < fpwo_pkg::NumPoints; k++) begin
			data_c[1 + 2 * fpwo_pkg::CoordBits * k +: fpwo_pkg::CoordBits] = ordered[k].x;
			data_c[1 + 2 * fpwo_pkg::CoordBits * k + fpwo_pkg::CoordBits
				+: fpwo_pkg::CoordBits] = ordered[k].y;
		end
	end

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_q  <= 1'b0;
		end else if (advance) begin
			valid_s1 <= s_tvalid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_q  <= valid_s3;
		end
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		if (advance) begin
			found_s1 <= (s_tdata[fpwo_pkg::CountBits-1:0] == fpwo_pkg::WandCount);
			pts_s1   <= pts_in;
			found_s2 <= found_s1;
			pts_s2   <= pts_s1;
			dist_s2  <= dist_c;
			found_s3 <= found_s2;
			pts_s3   <= pts_s2;
			dist_s3  <= dist_s2;
			pick_s3  <= pick_c;
			data_q   <= data_c;
		end
	end

`ifndef SYNTH
	// An accepted word enters the first stage
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> valid_s1)
		else $error("accepted word did not enter stage one");

	// A word in the last stage reaches the output when the pipe moves
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && valid_s3 |=> m_tvalid)
		else $error("last stage word lost");

	// A rejected point set carries all-zero coordinates
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> (m_tdata == '0))
		else $error("rejected word has nonzero coordinates");

	// If the farthest and closest pairs coincide, pairs 01 and 23 must be at equal distance
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && (pick_s3.pmin == pick_s3.pmax) |-> (dist_s3[0] == dist_s3[5]))
		else $error("min and max pair coincide on distinct distances");
`endif

endmodule
